// ----- design/hpq_pkg.sv -----
// Shared types, constants and codes for the dual Hall pulse tamper qualifier.
`default_nettype none

package hpq_pkg;

    localparam int unsigned TICK_W      = 8;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned IN_USER_W   = 3;
    localparam int unsigned OUT_DATA_W  = 24;

    localparam logic [TICK_W-1:0]  TICKS_RESET = TICK_W'(20);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_FALL_A = 3'd1,
        OP_FALL_B = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_INIT   = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_A = 2'd0,
        REG_ATTACK_A = 2'd1,
        REG_FILTER_B = 2'd2,
        REG_ATTACK_B = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_opcode opcode;
        logic    hall_a_level;
        logic    hall_b_level;
        logic    report_busy;
    } t_item;

    typedef struct packed {
        logic [TICK_W-1:0] filter_a;
        logic [TICK_W-1:0] attack_a;
        logic [TICK_W-1:0] filter_b;
        logic [TICK_W-1:0] attack_b;
    } t_cfg;

    typedef struct packed {
        logic               volume_pulse;
        logic               attack_event;
        logic               cancel_event;
        logic               tamper;
        logic               check_active;
        logic [COUNT_W-1:0] pending_a_count;
    } t_result;

    // Outcome of one tick of one channel check.
    typedef struct packed {
        logic              run;
        logic              phase;
        logic [TICK_W-1:0] ticks;
        logic              pulse;
        logic              limit;
    } t_chan_res;

endpackage

`default_nettype wire

// ----- design/hpq_chan.sv -----
// One tick of a single channel check: filter phase, then wait for the other line.
`default_nettype none

module hpq_chan (
    input  wire logic                       i_phase,
    input  wire logic [hpq_pkg::TICK_W-1:0] i_ticks,
    input  wire logic [hpq_pkg::TICK_W-1:0] i_filter,
    input  wire logic [hpq_pkg::TICK_W-1:0] i_attack,
    input  wire logic                       i_own_high,
    input  wire logic                       i_other_high,
    output hpq_pkg::t_chan_res              o_res
);
    import hpq_pkg::*;

    logic [TICK_W-1:0] w_ticks_inc;

    assign w_ticks_inc = i_ticks + TICK_W'(1);

    always_comb begin
        o_res.run   = 1'b1;
        o_res.phase = i_phase;
        o_res.ticks = w_ticks_inc;
        o_res.pulse = 1'b0;
        o_res.limit = 1'b0;
        if (!i_phase) begin
            if (i_own_high) begin
                o_res.run = 1'b0;
            end else if (w_ticks_inc >= i_filter) begin
                o_res.ticks = '0;
                o_res.phase = 1'b1;
            end
        end else begin
            if (i_other_high) begin
                o_res.pulse = 1'b1;
                o_res.run   = 1'b0;
            end else if (w_ticks_inc >= i_attack) begin
                o_res.limit = 1'b1;
                o_res.run   = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/hpq_core.sv -----
// Channel and tamper state with the per-transaction update logic.
`default_nettype none

module hpq_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_advance,
    input  hpq_pkg::t_item      i_item,
    input  hpq_pkg::t_cfg       i_cfg,
    output hpq_pkg::t_result    o_result
);
    import hpq_pkg::*;

    logic               r_run_a, r_phase_a, r_run_b, r_phase_b, r_tamper;
    logic [TICK_W-1:0]  r_ticks_a, r_ticks_b;
    logic [COUNT_W-1:0] r_count_a, r_count_b;

    logic               n_run_a, n_phase_a, n_run_b, n_phase_b, n_tamper;
    logic [TICK_W-1:0]  n_ticks_a, n_ticks_b;
    logic [COUNT_W-1:0] n_count_a, n_count_b;
    logic               w_volume, w_attack, w_cancel;

    t_chan_res w_res_a, w_res_b;

    hpq_chan u_chan_a (
        .i_phase      (r_phase_a),
        .i_ticks      (r_ticks_a),
        .i_filter     (i_cfg.filter_a),
        .i_attack     (i_cfg.attack_a),
        .i_own_high   (i_item.hall_a_level),
        .i_other_high (i_item.hall_b_level),
        .o_res        (w_res_a)
    );

    hpq_chan u_chan_b (
        .i_phase      (r_phase_b),
        .i_ticks      (r_ticks_b),
        .i_filter     (i_cfg.filter_b),
        .i_attack     (i_cfg.attack_b),
        .i_own_high   (i_item.hall_b_level),
        .i_other_high (i_item.hall_a_level),
        .o_res        (w_res_b)
    );

    always_comb begin
        n_run_a   = r_run_a;
        n_phase_a = r_phase_a;
        n_ticks_a = r_ticks_a;
        n_run_b   = r_run_b;
        n_phase_b = r_phase_b;
        n_ticks_b = r_ticks_b;
        n_count_a = r_count_a;
        n_count_b = r_count_b;
        n_tamper  = r_tamper;
        w_volume  = 1'b0;
        w_attack  = 1'b0;
        w_cancel  = 1'b0;
        unique case (i_item.opcode)
            OP_TICK: begin
                // Channel A goes first, so its pulse and attack are seen by B.
                if (r_run_a) begin
                    n_run_a   = w_res_a.run;
                    n_phase_a = w_res_a.phase;
                    n_ticks_a = w_res_a.ticks;
                    if (w_res_a.pulse && (r_count_a != COUNT_MAX)) begin
                        n_count_a = r_count_a + COUNT_W'(1);
                    end
                    if (w_res_a.limit && !r_tamper && !i_item.report_busy) begin
                        n_tamper = 1'b1;
                        w_attack = 1'b1;
                    end
                end
                if (r_run_b) begin
                    n_run_b   = w_res_b.run;
                    n_phase_b = w_res_b.phase;
                    n_ticks_b = w_res_b.ticks;
                    if (w_res_b.pulse) begin
                        if (n_count_a != '0) begin
                            n_count_a = '0;
                            n_count_b = '0;
                            w_volume  = 1'b1;
                        end else if (r_count_b != COUNT_MAX) begin
                            n_count_b = r_count_b + COUNT_W'(1);
                        end
                    end
                    if (w_res_b.limit && !n_tamper && !i_item.report_busy) begin
                        n_tamper = 1'b1;
                        w_attack = 1'b1;
                    end
                end
            end
            OP_FALL_A: begin
                n_run_a   = 1'b1;
                n_phase_a = 1'b0;
                n_ticks_a = '0;
            end
            OP_FALL_B: begin
                n_run_b   = 1'b1;
                n_phase_b = 1'b0;
                n_ticks_b = '0;
            end
            OP_CLEAR: begin
                if (r_tamper && (i_item.hall_a_level || i_item.hall_b_level)) begin
                    n_tamper = 1'b0;
                    w_cancel = 1'b1;
                end
            end
            OP_INIT: begin
                if (i_item.hall_a_level || i_item.hall_b_level) begin
                    n_tamper = 1'b0;
                    w_cancel = 1'b1;
                end else begin
                    n_tamper = 1'b1;
                    w_attack = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.volume_pulse    = w_volume;
        o_result.attack_event    = w_attack;
        o_result.cancel_event    = w_cancel;
        o_result.tamper          = n_tamper;
        o_result.check_active    = n_run_a | n_run_b;
        o_result.pending_a_count = n_count_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_a   <= 1'b0;
            r_phase_a <= 1'b0;
            r_ticks_a <= '0;
            r_run_b   <= 1'b0;
            r_phase_b <= 1'b0;
            r_ticks_b <= '0;
            r_count_a <= '0;
            r_count_b <= '0;
            r_tamper  <= 1'b0;
        end else if (i_advance) begin
            r_run_a   <= n_run_a;
            r_phase_a <= n_phase_a;
            r_ticks_a <= n_ticks_a;
            r_run_b   <= n_run_b;
            r_phase_b <= n_phase_b;
            r_ticks_b <= n_ticks_b;
            r_count_a <= n_count_a;
            r_count_b <= n_count_b;
            r_tamper  <= n_tamper;
        end
    end

    a_volume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.volume_pulse) |=> (r_count_a == '0) && (r_count_b == '0))
        else $error("volume increment did not clear both counts");

    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.attack_event && o_result.cancel_event))
        else $error("attack and cancel events in one transaction");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_count_a) && $stable(r_tamper) && $stable(r_run_a)
                       && $stable(r_run_b))
        else $error("state changed without a transaction");

    a_fall_a_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && (i_item.opcode == OP_FALL_A)) |=> r_run_a && !r_phase_a
                                                        && (r_ticks_a == '0))
        else $error("fall on A did not restart channel A");

    a_attack_sets_tamper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.attack_event) |=> r_tamper)
        else $error("attack event without tamper state");

endmodule

`default_nettype wire

// ----- design/dual_hall_pulse_tamper_qualifier_core.sv -----
// Top level: stream ports, configuration registers, input and result registers.
// Path: a transaction accepted into the input register passes through the core into the
// result register, which offers it on the result stream.
// Throughput: one transaction per cycle while the result stream is not stalled; the
// single-pass update of the channel state between the input register and the result register sets that figure.
// Reset: synchronous, active low; clears all channel and tamper state, empties both
// registers and sets the four tick limits to 20.
`default_nettype none

module dual_hall_pulse_tamper_qualifier_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port, one 8-bit register per index.
    input  wire logic                          i_cfg_we,
    input  wire logic [hpq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hpq_pkg::TICK_W-1:0]    i_cfg_data,
    // Input stream.
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // tdata: [0] hall_a_level, [1] hall_b_level, [2] report_busy, [7:3] zero
    input  wire logic [hpq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: [2:0] opcode
    input  wire logic [hpq_pkg::IN_USER_W-1:0] s_axis_tuser,
    // Result stream.
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: [0] volume_pulse, [1] attack_event, [2] cancel_event, [3] tamper,
    //        [4] check_active, [20:5] pending_a_count, [23:21] zero
    output      logic [hpq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import hpq_pkg::*;

    // Tick limits. Software writes these only while no transaction is in flight.
    t_cfg r_cfg;

    // Input register: one held transaction waiting for the core.
    logic  r_in_valid;
    t_item r_item;

    // Result register.
    logic    r_out_valid;
    t_result r_result;

    t_result w_result;
    logic    w_advance;

    // The held transaction moves through the core when the result register is
    // free or is being emptied in this cycle; the input register refills at once.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_a <= TICKS_RESET;
            r_cfg.attack_a <= TICKS_RESET;
            r_cfg.filter_b <= TICKS_RESET;
            r_cfg.attack_b <= TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FILTER_A: r_cfg.filter_a <= i_cfg_data;
                REG_ATTACK_A: r_cfg.attack_a <= i_cfg_data;
                REG_FILTER_B: r_cfg.filter_b <= i_cfg_data;
                REG_ATTACK_B: r_cfg.attack_b <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.opcode       <= t_opcode'(s_axis_tuser);
            r_item.hall_a_level <= s_axis_tdata[0];
            r_item.hall_b_level <= s_axis_tdata[1];
            r_item.report_busy  <= s_axis_tdata[2];
        end
    end

    hpq_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_item),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000,
                            r_result.pending_a_count,
                            r_result.check_active,
                            r_result.tamper,
                            r_result.cancel_event,
                            r_result.attack_event,
                            r_result.volume_pulse};

endmodule

`default_nettype wire

// ----- tb/tb_dual_hall_pulse_tamper_qualifier_core.sv -----
// Self-checking stream testbench for the dual Hall pulse tamper qualifier core.
`timescale 1ns / 1ps

module tb_dual_hall_pulse_tamper_qualifier_core;
    import hpq_pkg::*;

    // Opcodes the block does not define; they must leave every piece of state alone.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int CH_A = 0;
    localparam int CH_B = 1;

    localparam logic [TICK_W-1:0] LIM_MIN = 8'd1;
    localparam logic [TICK_W-1:0] LIM_MAX = 8'd255;

    localparam int DIR_ROWS        = 25;
    localparam int DRAIN_CYCLES    = 6;     // settling margin after the last result
    localparam int PRESSURE_CYCLES = 200;
    localparam int PRESSURE_ITEMS  = 80;
    localparam int PAIR_LOOPS      = 25;
    localparam int MAX_PRINTS      = 40;

    // One input transaction as the testbench sees it. The opcode is kept as raw bits
    // so that the undefined codes can be sent as well.
    typedef struct packed {
        logic [2:0] op;
        logic       hall_a;
        logic       hall_b;
        logic       busy;
    } t_stim;

    // One row of the directed table. When typed is set, want is the outcome written
    // by hand; otherwise the predictor supplies the outcome.
    typedef struct packed {
        logic [TICK_W-1:0] limit;
        t_stim             item;
        bit                typed;
        t_result           want;
    } t_row;

    // ---------------------------------------------------------------------------
    // Clock, reset and the signals driven into the block. Every input starts at a
    // known value at time zero.
    // ---------------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [TICK_W-1:0]      i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    dual_hall_pulse_tamper_qualifier_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------
    // Predictor state: a private copy of both channel checks, the pulse counts, the
    // tamper flag and the tick limits currently loaded into the block.
    // ---------------------------------------------------------------------------
    logic              chk_run   [2];
    logic              chk_phase [2];     // 0 filter phase, 1 waiting for the other line
    logic [TICK_W-1:0] chk_ticks [2];
    logic [COUNT_W-1:0] a_pulses;
    logic [COUNT_W-1:0] b_pulses;
    logic              tamper_st;
    t_cfg              lim;
    logic              vol_ev;
    logic              atk_ev;

    t_result outcome_q [$];   // outcomes still owed by the block, oldest first

    int mismatch_count   = 0;
    int items_sent       = 0;
    int outcomes_checked = 0;
    int volume_seen      = 0;
    int attack_seen      = 0;
    int cancel_seen      = 0;
    int settings_loaded  = 0;

    // Traffic shaping shared by the two sides. With idle_on clear neither side
    // inserts gaps; pressure_req asks the receiver for one long hold-off.
    bit idle_on       = 1'b1;
    bit pressure_req  = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left     = 0;

    // Line model for the random part: current level and remaining ticks per line.
    logic line_lvl  [2];
    int   line_hold [2];

    t_row dir_table [DIR_ROWS];

    // A detected attack is written only from the normal state and never while a
    // report is in progress.
    function automatic void raise_tamper(input logic busy);
        if (!tamper_st && !busy) begin
            tamper_st = 1'b1;
            atk_ev    = 1'b1;
        end
    endfunction

    // One timer tick of one running channel; returns whether it keeps running.
    function automatic logic step_channel(input int ch, input logic [TICK_W-1:0] filt,
                                          input logic [TICK_W-1:0] atk, input logic own_high,
                                          input logic other_high, input logic busy);
        chk_ticks[ch] = chk_ticks[ch] + 1'b1;
        if (!chk_phase[ch]) begin
            // Filter phase: the channel's own line must stay low.
            if (own_high)
                return 1'b0;
            if (chk_ticks[ch] >= filt) begin
                chk_ticks[ch] = '0;
                chk_phase[ch] = 1'b1;
            end
            return 1'b1;
        end
        if (other_high) begin
            // A valid pulse. A B pulse closes an A-then-B pair if any A pulse waits.
            if (ch == CH_A) begin
                if (a_pulses != COUNT_MAX)
                    a_pulses = a_pulses + 1'b1;
            end else if (a_pulses != '0) begin
                a_pulses = '0;
                b_pulses = '0;
                vol_ev   = 1'b1;
            end else if (b_pulses != COUNT_MAX) begin
                b_pulses = b_pulses + 1'b1;
            end
            return 1'b0;
        end
        if (chk_ticks[ch] >= atk) begin
            raise_tamper(busy);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the private copy by one input transaction and returns its outcome.
    function automatic t_result qualify_item(input t_stim it);
        t_result r;
        logic    cancel_ev;
        int      ch;
        cancel_ev = 1'b0;
        vol_ev    = 1'b0;
        atk_ev    = 1'b0;
        case (it.op)
            OP_TICK: begin
                // Channel A is always evaluated before channel B.
                if (chk_run[CH_A])
                    chk_run[CH_A] = step_channel(CH_A, lim.filter_a, lim.attack_a,
                                                 it.hall_a, it.hall_b, it.busy);
                if (chk_run[CH_B])
                    chk_run[CH_B] = step_channel(CH_B, lim.filter_b, lim.attack_b,
                                                 it.hall_b, it.hall_a, it.busy);
            end
            OP_FALL_A, OP_FALL_B: begin
                ch = (it.op == OP_FALL_A) ? CH_A : CH_B;
                chk_ticks[ch] = '0;
                chk_phase[ch] = 1'b0;
                chk_run[ch]   = 1'b1;
            end
            OP_CLEAR: begin
                if (tamper_st && (it.hall_a || it.hall_b)) begin
                    tamper_st = 1'b0;
                    cancel_ev = 1'b1;
                end
            end
            OP_INIT: begin
                // The initial check ignores report_busy and always logs an event.
                if (it.hall_a || it.hall_b) begin
                    tamper_st = 1'b0;
                    cancel_ev = 1'b1;
                end else begin
                    tamper_st = 1'b1;
                    atk_ev    = 1'b1;
                end
            end
            default: ;
        endcase
        r.volume_pulse    = vol_ev;
        r.attack_event    = atk_ev;
        r.cancel_event    = cancel_ev;
        r.tamper          = tamper_st;
        r.check_active    = chk_run[CH_A] || chk_run[CH_B];
        r.pending_a_count = a_pulses;
        return r;
    endfunction

    function automatic t_row dir_row(input logic [TICK_W-1:0] limit, input logic [2:0] op,
                                     input logic a, input logic b, input logic busy,
                                     input bit typed, input t_result want);
        t_row r;
        r.limit = limit;
        r.item  = t_stim'{op, a, b, busy};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one, none while idling is switched off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // A line holds its level for up to about one and a half times the full check
    // length of its channel, so that both pulses and attacks come up.
    function automatic int new_hold(input int ch);
        int span;
        span = (ch == CH_A) ? lim.filter_a + lim.attack_a : lim.filter_b + lim.attack_b;
        return $urandom_range(0, span + span / 2 + 2);
    endfunction

    // Next random transaction. Most are timer ticks that follow the line model, with
    // a falling edge reported when a line drops; a few drops go unreported, and a
    // small share is clear checks, initial checks and plain noise.
    function automatic t_stim next_line_item();
        t_stim it;
        int    r;
        int    ch;
        bit    fell;
        r    = $urandom_range(0, 99);
        fell = 1'b0;
        it.busy = ($urandom_range(0, 9) == 0);
        if (r < 3) begin
            it.op     = 3'($urandom_range(0, 7));
            it.hall_a = 1'($urandom_range(0, 1));
            it.hall_b = 1'($urandom_range(0, 1));
            it.busy   = 1'($urandom_range(0, 1));
            return it;
        end
        it.op = OP_TICK;
        if (r < 5) begin
            it.op = OP_CLEAR;
        end else if (r < 6) begin
            it.op = OP_INIT;
        end else begin
            for (ch = CH_A; ch <= CH_B; ch++) begin
                if (!fell) begin
                    if (line_hold[ch] == 0) begin
                        line_lvl[ch]  = ~line_lvl[ch];
                        line_hold[ch] = new_hold(ch);
                        if (!line_lvl[ch] && $urandom_range(0, 19) != 0) begin
                            it.op = (ch == CH_A) ? OP_FALL_A : OP_FALL_B;
                            fell  = 1'b1;
                        end
                    end else begin
                        line_hold[ch]--;
                    end
                end
            end
        end
        it.hall_a = line_lvl[CH_A];
        it.hall_b = line_lvl[CH_B];
        return it;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                     $realtime, outcomes_checked, field, want, got);
    endtask

    // Compares one result transaction field by field with the oldest outcome owed.
    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        t_result want;
        if (outcome_q.size() == 0) begin
            report_mismatch("unexpected result", 0, d);
            return;
        end
        want = outcome_q.pop_front();
        if (d[0] !== want.volume_pulse)
            report_mismatch("volume_pulse", want.volume_pulse, d[0]);
        if (d[1] !== want.attack_event)
            report_mismatch("attack_event", want.attack_event, d[1]);
        if (d[2] !== want.cancel_event)
            report_mismatch("cancel_event", want.cancel_event, d[2]);
        if (d[3] !== want.tamper)
            report_mismatch("tamper", want.tamper, d[3]);
        if (d[4] !== want.check_active)
            report_mismatch("check_active", want.check_active, d[4]);
        if (d[20:5] !== want.pending_a_count)
            report_mismatch("pending_a_count", want.pending_a_count, d[20:5]);
        if (d[23:21] !== 3'b000)
            report_mismatch("padding", 0, d[23:21]);
        outcomes_checked++;
        volume_seen += want.volume_pulse;
        attack_seen += want.attack_event;
        cancel_seen += want.cancel_event;
    endtask

    // ---------------------------------------------------------------------------
    // Receiver. Results are sampled at the rising edge, so the values seen are the
    // ones the block held at that edge. Ready then gets a random hold-off, the one
    // long hold-off on request, or stays high while idling is off.
    // ---------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            hold_left = pick_gap();
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one transaction after a random gap and waits for it to be taken. The
    // outcome is worked out at the edge of acceptance, while the transaction enters the
    // input register and before the block can show the result.
    task automatic send_item(input t_stim it, input bit typed, input t_result want);
        int      gap;
        t_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, it.busy, it.hall_b, it.hall_a};
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = qualify_item(it);
        outcome_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Stops offering and waits until every result has come back and the block has
    // settled. Called in the step of the last acceptance.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [TICK_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Writes all four tick limits back to back; only called while the block is idle.
    task automatic load_config(input t_cfg c);
        write_reg(REG_FILTER_A, c.filter_a);
        write_reg(REG_ATTACK_A, c.attack_a);
        write_reg(REG_FILTER_B, c.filter_b);
        write_reg(REG_ATTACK_B, c.attack_b);
        i_cfg_we <= 1'b0;
        lim = c;
        settings_loaded++;
    endtask

    // One random phase under one setting of the limits. With squeeze set, the phase
    // opens with a gapless burst against the receiver's long hold-off, so that the
    // block fills up and drops its input ready.
    task automatic run_random(input t_cfg c, input int n, input bit squeeze);
        int k;
        wait_idle();
        load_config(c);
        line_lvl[CH_A]  = 1'b1;
        line_lvl[CH_B]  = 1'b1;
        line_hold[CH_A] = new_hold(CH_A);
        line_hold[CH_B] = new_hold(CH_B);
        for (k = 0; k < n; k++) begin
            if (squeeze && k == 0) begin
                idle_on      = 1'b0;
                pressure_req = 1'b1;
            end else if (!(squeeze && k < PRESSURE_ITEMS) && k % 64 == 0) begin
                // Stretches without any idling on either side now and then.
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_item(next_line_item(), 1'b0, '0);
        end
        idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------------------------
    // Stimulus.
    // ---------------------------------------------------------------------------
    initial begin
        t_cfg              c;
        logic [TICK_W-1:0] cur_limit;
        int                k;

        chk_run   = '{1'b0, 1'b0};
        chk_phase = '{1'b0, 1'b0};
        chk_ticks = '{8'd0, 8'd0};
        a_pulses  = '0;
        b_pulses  = '0;
        tamper_st = 1'b0;
        lim       = t_cfg'{TICKS_RESET, TICKS_RESET, TICKS_RESET, TICKS_RESET};
        cur_limit = TICKS_RESET;

        // Expected outcome bits from the left: volume_pulse, attack_event,
        // cancel_event, tamper, check_active, then the pending A count.
        dir_table = '{
            // Reset limits: opcodes, the tamper state and the undefined codes.
            dir_row(TICKS_RESET, OP_TICK,    1'b0, 1'b0, 1'b0, 1'b1, {5'b00000, 16'd0}),
            dir_row(TICKS_RESET, OP_SPARE_7, 1'b1, 1'b1, 1'b1, 1'b1, {5'b00000, 16'd0}),
            // The initial check logs an attack even while a report is busy.
            dir_row(TICKS_RESET, OP_INIT,    1'b0, 1'b0, 1'b1, 1'b1, {5'b01010, 16'd0}),
            dir_row(TICKS_RESET, OP_SPARE_5, 1'b0, 1'b0, 1'b0, 1'b1, {5'b00010, 16'd0}),
            // The clear check needs a high line.
            dir_row(TICKS_RESET, OP_CLEAR,   1'b0, 1'b0, 1'b0, 1'b1, {5'b00010, 16'd0}),
            dir_row(TICKS_RESET, OP_CLEAR,   1'b0, 1'b1, 1'b0, 1'b1, {5'b00100, 16'd0}),
            // ... and does nothing in the normal state.
            dir_row(TICKS_RESET, OP_CLEAR,   1'b1, 1'b0, 1'b0, 1'b1, {5'b00000, 16'd0}),
            dir_row(TICKS_RESET, OP_INIT,    1'b1, 1'b0, 1'b0, 1'b1, {5'b00100, 16'd0}),
            dir_row(TICKS_RESET, OP_INIT,    1'b0, 1'b0, 1'b0, 1'b1, {5'b01010, 16'd0}),
            dir_row(TICKS_RESET, OP_INIT,    1'b1, 1'b1, 1'b1, 1'b1, {5'b00100, 16'd0}),
            dir_row(TICKS_RESET, OP_FALL_A,  1'b1, 1'b1, 1'b0, 1'b1, {5'b00001, 16'd0}),
            // Own line high during the filter phase ends the A check.
            dir_row(TICKS_RESET, OP_TICK,    1'b1, 1'b0, 1'b0, 1'b1, {5'b00000, 16'd0}),
            dir_row(TICKS_RESET, OP_FALL_B,  1'b0, 1'b0, 1'b1, 1'b1, {5'b00001, 16'd0}),
            dir_row(TICKS_RESET, OP_SPARE_6, 1'b1, 1'b0, 1'b1, 1'b1, {5'b00001, 16'd0}),
            // Limits of one: the B check left running passes its filter, then its
            // attack is swallowed by a busy report.
            dir_row(LIM_MIN,     OP_TICK,    1'b0, 1'b0, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_TICK,    1'b0, 1'b0, 1'b1, 1'b0, '0),
            // Both channels pulse in one tick: A is counted first, so B completes a
            // pair and clears the counts.
            dir_row(LIM_MIN,     OP_FALL_A,  1'b0, 1'b0, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_FALL_B,  1'b1, 1'b1, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_TICK,    1'b0, 1'b0, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_TICK,    1'b1, 1'b1, 1'b0, 1'b0, '0),
            // Both channels reach the attack limit in one tick: only A raises it.
            dir_row(LIM_MIN,     OP_FALL_A,  1'b0, 1'b1, 1'b1, 1'b0, '0),
            dir_row(LIM_MIN,     OP_FALL_B,  1'b0, 1'b0, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_TICK,    1'b0, 1'b0, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_TICK,    1'b0, 1'b0, 1'b0, 1'b0, '0),
            dir_row(LIM_MIN,     OP_INIT,    1'b1, 1'b0, 1'b0, 1'b1, {5'b00100, 16'd0})
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The limits start at their reset values; a row that asks
        // for other limits first drains the block and reloads all four registers.
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_table[k].limit != cur_limit) begin
                wait_idle();
                cur_limit = dir_table[k].limit;
                load_config(t_cfg'{cur_limit, cur_limit, cur_limit, cur_limit});
            end
            send_item(dir_table[k].item, dir_table[k].typed, dir_table[k].want);
        end

        // Random part over several settings, the extremes among them.
        run_random(t_cfg'{LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX}, 500, 1'b1);
        c.filter_a = 8'($urandom_range(1, 8));
        c.attack_a = 8'($urandom_range(1, 8));
        c.filter_b = 8'($urandom_range(1, 8));
        c.attack_b = 8'($urandom_range(1, 8));
        run_random(c, 300, 1'b0);
        run_random(t_cfg'{LIM_MIN, LIM_MIN, LIM_MIN, LIM_MIN}, 150, 1'b0);
        run_random(t_cfg'{TICKS_RESET, TICKS_RESET, TICKS_RESET, TICKS_RESET}, 150, 1'b0);
        run_random(t_cfg'{LIM_MIN, LIM_MAX, LIM_MAX, LIM_MIN}, 150, 1'b0);
        c.filter_a = 8'($urandom_range(1, 255));
        c.attack_a = 8'($urandom_range(1, 255));
        c.filter_b = 8'($urandom_range(1, 255));
        c.attack_b = 8'($urandom_range(1, 255));
        run_random(c, 250, 1'b0);

        // Pulse counting: a run of A pulses, three transactions each, builds up the
        // pending A count; then one B pulse closes the pair and clears it. The first
        // tick stops whatever checks are still open.
        wait_idle();
        load_config(t_cfg'{LIM_MIN, LIM_MAX, LIM_MIN, LIM_MAX});
        idle_on = 1'b0;
        send_item(t_stim'{OP_TICK, 1'b1, 1'b1, 1'b0}, 1'b0, '0);
        for (k = 0; k < PAIR_LOOPS; k++) begin
            send_item(t_stim'{OP_FALL_A, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
            send_item(t_stim'{OP_TICK, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
            send_item(t_stim'{OP_TICK, 1'b0, 1'b1, 1'b0}, 1'b0, '0);
        end
        send_item(t_stim'{OP_FALL_B, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        send_item(t_stim'{OP_TICK, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        send_item(t_stim'{OP_TICK, 1'b1, 1'b0, 1'b0}, 1'b0, '0);
        idle_on = 1'b1;

        // Every outcome owed must arrive; a missing one ends in the timeout below.
        wait_idle();

        $display("Run covered %0d transactions in and %0d results checked, with %0d volume",
                 items_sent, outcomes_checked, volume_seen);
        $display("pulses, %0d attack and %0d cancel events over %0d limit settings.",
                 attack_seen, cancel_seen, settings_loaded);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: many times the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", outcome_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
